// ===== rtl/core/b2da_pkg.sv =====
// ----------------------------------------------------------------------------
// b2da_pkg: shared types and constants for the binary to decimal ASCII block
// Holds widths, the sequencer state type and the ASCII digit mapping.
// ----------------------------------------------------------------------------
package b2da_pkg;

   // binary input width and number of decimal digits kept
   localparam int VALUE_WIDTH = 32;
   localparam int MAX_DIGITS  = 10;

   // derived widths
   localparam int DIGIT_W = 4;
   localparam int BCD_W   = MAX_DIGITS * DIGIT_W;
   localparam int CNT_W   = (VALUE_WIDTH > 1) ? $clog2(VALUE_WIDTH) : 1;
   localparam int DIG_W   = (MAX_DIGITS > 1) ? $clog2(MAX_DIGITS) : 1;
   localparam int CHAR_W  = 6;

   // last bit index and last digit index for the counters
   localparam logic [CNT_W-1:0] BIT_LAST   = CNT_W'(VALUE_WIDTH - 1);
   localparam logic [DIG_W-1:0] DIGIT_LAST = DIG_W'(MAX_DIGITS - 1);

   // ascii code of character zero, reduced to the character width
   localparam logic [CHAR_W-1:0] ASCII_ZERO = CHAR_W'(48);

   // correction threshold and offset of the shift-add-3 step
   localparam logic [DIGIT_W-1:0] DABBLE_LIMIT = DIGIT_W'(5);
   localparam logic [DIGIT_W-1:0] DABBLE_ADD   = DIGIT_W'(3);

   // sequencer states
   typedef enum logic [1:0] {
      ST_IDLE,
      ST_CONVERT,
      ST_SKIP,
      ST_EMIT
   } state_type;

   // map one bcd digit to its ascii character
   function automatic logic [CHAR_W-1:0] digit_to_char(input logic [DIGIT_W-1:0] digit);
      digit_to_char = ASCII_ZERO + CHAR_W'(digit);
   endfunction

endpackage

// ===== rtl/core/b2da_dabble_unit.sv =====
// ----------------------------------------------------------------------------
// b2da_dabble_unit: one shift-add-3 step of the binary to bcd conversion
// Corrects every bcd digit of 5 or more by adding 3, then shifts the joined
// bcd and binary words left by one bit. Used once per convert cycle by the sequencer.
// ----------------------------------------------------------------------------
module b2da_dabble_unit (
   input  logic [b2da_pkg::BCD_W-1:0]       bcd_cur,
   input  logic [b2da_pkg::VALUE_WIDTH-1:0] bin_cur,
   output logic [b2da_pkg::BCD_W-1:0]       bcd_nxt,
   output logic [b2da_pkg::VALUE_WIDTH-1:0] bin_nxt
);

   logic [b2da_pkg::BCD_W-1:0] bcd_fix;

   // per-digit correction, lanes are independent
   always_comb begin
      for (int d = 0; d < b2da_pkg::MAX_DIGITS; d++) begin
         if (bcd_cur[d*b2da_pkg::DIGIT_W +: b2da_pkg::DIGIT_W] >= b2da_pkg::DABBLE_LIMIT) begin
            bcd_fix[d*b2da_pkg::DIGIT_W +: b2da_pkg::DIGIT_W] =
               bcd_cur[d*b2da_pkg::DIGIT_W +: b2da_pkg::DIGIT_W] + b2da_pkg::DABBLE_ADD;
         end else begin
            bcd_fix[d*b2da_pkg::DIGIT_W +: b2da_pkg::DIGIT_W] =
               bcd_cur[d*b2da_pkg::DIGIT_W +: b2da_pkg::DIGIT_W];
         end
      end
   end

   // shift binary msb into the bcd word, top digit carry drops out
   assign bcd_nxt = {bcd_fix[b2da_pkg::BCD_W-2:0], bin_cur[b2da_pkg::VALUE_WIDTH-1]};
   assign bin_nxt = {bin_cur[b2da_pkg::VALUE_WIDTH-2:0], 1'b0};

endmodule

// ===== rtl/core/binary_to_decimal_ascii_top.sv =====
// ----------------------------------------------------------------------------
// binary_to_decimal_ascii_top: unsigned binary to decimal ascii characters
// Converts one value per request beat into its decimal digits, most
// significant first, leading zeros dropped, last beat flagged.
// ----------------------------------------------------------------------------
//  channel | ports                                  | direction
//  --------+----------------------------------------+----------
//  request | req_valid, req_stall, req_value        | in
//  result  | rsp_valid, rsp_stall, rsp_digit_char,  | out
//          | rsp_last                               |
//
//  one request runs through the idle, convert, skip and emit states, plus any
//  result stall; skipped and emitted digits always add up to MAX_DIGITS.
//  the shift-add-3 unit takes one bit per cycle; a digit leaves per cycle
//  while rsp_stall is low.
//  req_stall is high from the accepted beat until the last digit is taken.
//  a stalled digit holds in the bcd register; reset returns to idle.
// ----------------------------------------------------------------------------
module binary_to_decimal_ascii_top (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_valid,
   output logic                                req_stall,
   input  logic [b2da_pkg::VALUE_WIDTH-1:0]    req_value,
   output logic                                rsp_valid,
   input  logic                                rsp_stall,
   output logic [b2da_pkg::CHAR_W-1:0]         rsp_digit_char,
   output logic                                rsp_last
);

   b2da_pkg::state_type state_ff, state_in;

   logic [b2da_pkg::BCD_W-1:0]       bcd_ff, bcd_in;
   logic [b2da_pkg::VALUE_WIDTH-1:0] bin_ff, bin_in;
   logic [b2da_pkg::CNT_W-1:0]       bit_cnt_ff, bit_cnt_in;
   logic [b2da_pkg::DIG_W-1:0]       dig_cnt_ff, dig_cnt_in;

   logic [b2da_pkg::BCD_W-1:0]       bcd_step;
   logic [b2da_pkg::VALUE_WIDTH-1:0] bin_step;
   logic [b2da_pkg::DIGIT_W-1:0]     top_digit;
   logic [b2da_pkg::BCD_W-1:0]       bcd_shifted;
   logic                             req_beat;
   logic                             rsp_beat;

   // shared conversion unit
   b2da_dabble_unit u_dabble (
      .bcd_cur (bcd_ff),
      .bin_cur (bin_ff),
      .bcd_nxt (bcd_step),
      .bin_nxt (bin_step)
   );

   // digit at the head of the bcd word and the word moved up one digit
   assign top_digit   = bcd_ff[b2da_pkg::BCD_W-1 -: b2da_pkg::DIGIT_W];
   assign bcd_shifted = {bcd_ff[b2da_pkg::BCD_W-b2da_pkg::DIGIT_W-1:0],
                         {b2da_pkg::DIGIT_W{1'b0}}};

   assign req_beat = req_valid && !req_stall;
   assign rsp_beat = rsp_valid && !rsp_stall;

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         b2da_pkg::ST_IDLE: begin
            if (req_beat) state_in = b2da_pkg::ST_CONVERT;
         end
         b2da_pkg::ST_CONVERT: begin
            if (bit_cnt_ff == '0) state_in = b2da_pkg::ST_SKIP;
         end
         b2da_pkg::ST_SKIP: begin
            if (top_digit != '0 || dig_cnt_ff == '0) state_in = b2da_pkg::ST_EMIT;
         end
         b2da_pkg::ST_EMIT: begin
            if (rsp_beat && dig_cnt_ff == '0) state_in = b2da_pkg::ST_IDLE;
         end
         default: state_in = b2da_pkg::ST_IDLE;
      endcase
   end

   // outputs and datapath updates
   always_comb begin
      req_stall      = 1'b1;
      rsp_valid      = 1'b0;
      rsp_digit_char = b2da_pkg::digit_to_char(top_digit);
      rsp_last       = (dig_cnt_ff == '0);
      bcd_in         = bcd_ff;
      bin_in         = bin_ff;
      bit_cnt_in     = bit_cnt_ff;
      dig_cnt_in     = dig_cnt_ff;
      unique case (state_ff)
         b2da_pkg::ST_IDLE: begin
            req_stall  = 1'b0;
            bcd_in     = '0;
            bin_in     = req_value;
            bit_cnt_in = b2da_pkg::BIT_LAST;
            dig_cnt_in = b2da_pkg::DIGIT_LAST;
         end
         b2da_pkg::ST_CONVERT: begin
            bcd_in     = bcd_step;
            bin_in     = bin_step;
            bit_cnt_in = bit_cnt_ff - 1'b1;
         end
         b2da_pkg::ST_SKIP: begin
            // drop leading zero digits, keep the final one
            if (top_digit == '0 && dig_cnt_ff != '0) begin
               bcd_in     = bcd_shifted;
               dig_cnt_in = dig_cnt_ff - 1'b1;
            end
         end
         b2da_pkg::ST_EMIT: begin
            rsp_valid = 1'b1;
            if (rsp_beat && dig_cnt_ff != '0) begin
               bcd_in     = bcd_shifted;
               dig_cnt_in = dig_cnt_ff - 1'b1;
            end
         end
         default: begin
            req_stall = 1'b1;
         end
      endcase
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= b2da_pkg::ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      bcd_ff     <= bcd_in;
      bin_ff     <= bin_in;
      bit_cnt_ff <= bit_cnt_in;
      dig_cnt_ff <= dig_cnt_in;
   end

endmodule

// ===== verif/binary_to_decimal_ascii_tb.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// testbench: self-checking bench for binary_to_decimal_ascii_top
// Sends unsigned values over the request channel and predicts each decimal
// character beat (most significant first, no leading zeros, last flagged).
// Both channels idle at random, with some stretches running at full rate.
// ----------------------------------------------------------------------------
module testbench;

   localparam int            CYCLE_LIMIT     = 400000;
   localparam int            DRAIN_CYCLES    = 60;
   localparam int            MAX_IDLE        = 13;
   localparam logic [b2da_pkg::CHAR_W-1:0] DIGIT_ZERO_CODE = b2da_pkg::CHAR_W'(48);

   // one expected character beat
   typedef struct {
      logic [b2da_pkg::CHAR_W-1:0] digit_char;
      logic                        last;
   } char_beat_type;

   logic                             clock = 1'b0;
   logic                             reset = 1'b1;
   logic                             req_valid = 1'b0;
   logic                             req_stall;
   logic [b2da_pkg::VALUE_WIDTH-1:0] req_value = '0;
   logic                             rsp_valid;
   logic                             rsp_stall = 1'b0;
   logic [b2da_pkg::CHAR_W-1:0]      rsp_digit_char;
   logic                             rsp_last;

   char_beat_type pending_chars[$];
   int            error_count = 0;
   int            cycle_count = 0;
   int            stall_left  = 0;
   bit            full_rate   = 1'b0;

   binary_to_decimal_ascii_top DUT (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_stall      (req_stall),
      .req_value      (req_value),
      .rsp_valid      (rsp_valid),
      .rsp_stall      (rsp_stall),
      .rsp_digit_char (rsp_digit_char),
      .rsp_last       (rsp_last)
   );

   always #5 clock = ~clock;

   // decimal expansion of one value into the expected character beats
   function automatic void expand_decimal(input logic [b2da_pkg::VALUE_WIDTH-1:0] value);
      logic [63:0]   rest;
      logic [3:0]    digits[b2da_pkg::MAX_DIGITS];
      int            count;
      char_beat_type beat;
      rest  = 64'(value);
      count = 0;
      // least significant digit first, at most MAX_DIGITS of them
      while (rest != 0 && count < b2da_pkg::MAX_DIGITS) begin
         digits[count] = 4'(rest % 10);
         rest          = rest / 10;
         count++;
      end
      // drop zeros left on top after truncation
      while (count > 0 && digits[count-1] == 4'd0)
         count--;
      if (count == 0) begin
         digits[0] = 4'd0;
         count     = 1;
      end
      for (int k = count - 1; k >= 0; k--) begin
         beat.digit_char = DIGIT_ZERO_CODE + b2da_pkg::CHAR_W'(digits[k]);
         beat.last       = (k == 0);
         pending_chars.push_back(beat);
      end
   endfunction

   // send one value, predict its characters once the beat is taken
   task automatic send_value(input logic [b2da_pkg::VALUE_WIDTH-1:0] value);
      int gap;
      gap = full_rate ? 0 : $urandom_range(0, MAX_IDLE);
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_value <= value;
      do
         @(posedge clock);
      while (req_stall);
      expand_decimal(value);
   endtask

   // result side: check each taken beat, then draw the next stall
   always @(posedge clock) begin
      if (!reset) begin
         if (rsp_valid && !rsp_stall) begin
            if (pending_chars.size() == 0) begin
               $error("unexpected beat: digit_char %0d last %0d", rsp_digit_char, rsp_last);
               error_count++;
            end else begin
               char_beat_type want;
               want = pending_chars.pop_front();
               if (rsp_digit_char !== want.digit_char) begin
                  $error("digit_char mismatch: expected %0d, actual %0d",
                         want.digit_char, rsp_digit_char);
                  error_count++;
               end
               if (rsp_last !== want.last) begin
                  $error("last mismatch: expected %0d, actual %0d", want.last, rsp_last);
                  error_count++;
               end
            end
            stall_left = full_rate ? 0 : $urandom_range(0, MAX_IDLE);
            rsp_stall <= (stall_left > 0);
         end else if (rsp_valid && stall_left > 0) begin
            stall_left--;
            rsp_stall <= (stall_left > 0);
         end
      end
   end

   // watchdog
   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("binary_to_decimal_ascii_top verification failed");
         $finish;
      end
   end

   // extremes, zero, powers of ten and inner zeros
   task automatic test_directed_values();
      logic [b2da_pkg::VALUE_WIDTH-1:0] values[$];
      values = {32'd0, 32'd1, 32'd9, 32'd10, 32'd11, 32'd99, 32'd100, 32'd101,
                32'd1000, 32'd65535, 32'd65536, 32'd100200300, 32'd999999999,
                32'd1000000000, 32'd1000000001, 32'd2147483647, 32'd2147483648,
                32'd4000000000, 32'd4294967290, 32'd4294967294, 32'd4294967295,
                32'd0, 32'd7, 32'd1234567890};
      foreach (values[i])
         send_value(values[i]);
   endtask

   // walking one and walking zero over every bit
   task automatic test_bit_patterns();
      for (int i = 0; i < b2da_pkg::VALUE_WIDTH; i++) begin
         send_value(b2da_pkg::VALUE_WIDTH'(1) << i);
         send_value(~(b2da_pkg::VALUE_WIDTH'(1) << i));
      end
   endtask

   // uniform over the full 32-bit range, mostly ten-digit values
   task automatic test_full_range(input int count);
      repeat (count)
         send_value(b2da_pkg::VALUE_WIDTH'($urandom));
   endtask

   // pick the digit count first so short runs are as common as long ones
   task automatic test_digit_counts(input int count);
      longint unsigned lo, hi, span;
      int              ndig;
      repeat (count) begin
         ndig = $urandom_range(1, b2da_pkg::MAX_DIGITS);
         lo   = 1;
         for (int k = 1; k < ndig; k++)
            lo = lo * 10;
         hi = lo * 10 - 1;
         if (ndig == 1)
            lo = 0;
         if (hi > 64'hFFFF_FFFF)
            hi = 64'hFFFF_FFFF;
         span = hi - lo + 1;
         send_value(b2da_pkg::VALUE_WIDTH'(lo + ({$urandom, $urandom} % span)));
      end
   endtask

   // no idling on either side
   task automatic test_full_rate(input int count);
      full_rate = 1'b1;
      test_digit_counts(count);
      full_rate = 1'b0;
   endtask

   initial begin
      repeat (4) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      test_directed_values();
      test_bit_patterns();
      test_full_range(170);
      test_digit_counts(170);
      test_full_rate(70);

      req_valid <= 1'b0;
      while (pending_chars.size() != 0)
         @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);

      if (error_count == 0 && pending_chars.size() == 0) begin
         $display("binary_to_decimal_ascii_top verification clean");
      end else begin
         $display("binary_to_decimal_ascii_top verification failed");
      end
      $finish;
   end

endmodule
